/* rtl/core/rscp_pkg.sv */
// rscp_pkg: shared constants, datapath op codes and status struct for the
// sprite column projector. No dependencies.
package rscp_pkg;

    localparam int POS_FRAC_BITS = 8;
    localparam int VEC_FRAC_BITS = 14;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_PLACE  = 2'd1;
    localparam logic [1:0] CMD_COLUMN = 2'd2;

    localparam logic [2:0] REG_VIEW_WIDTH     = 3'd0;
    localparam logic [2:0] REG_VIEW_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_SHEET_ROW      = 3'd4;
    localparam logic [2:0] REG_FRAME_COUNT    = 3'd5;
    localparam logic [2:0] REG_FRAME_DURATION = 3'd6;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD,
        OP_DET_A, OP_DET_B, OP_TX_A, OP_TX_B, OP_TY_A, OP_TY_B, OP_NORM, OP_CLEAR,
        OP_CX_MUL, OP_CX_DIV, OP_CX_SET, OP_SZ_MUL, OP_SZ_DIV, OP_SZ_SET,
        OP_DP_DIV, OP_DP_SET, OP_GEOM,
        OP_TK_DIV, OP_TK_SET, OP_FR_ZERO, OP_FR_DIV, OP_FR_SET,
        OP_COL_MUL, OP_COL_DIV, OP_COL_SET, OP_TEX, OP_EMIT
    } t_op;

    typedef struct packed {
        logic       div_done;
        logic       geom_bad;
        logic       col_vis;
        logic       n_zero;
        logic       cnt_zero;
        logic       out_free;
        logic [1:0] cmd;
    } t_dp_status;

endpackage

/* rtl/core/raycast_sprite_column_projector.sv */
// raycast_sprite_column_projector: top level, joins rscp_ctrl and rscp_dp.
// Uses rscp_pkg, rscp_ctrl, rscp_dp (which holds rscp_div).
//
//   channel   direction   handshake                  word
//   in        input       i_in_valid / o_in_ready    cmd and item fields
//   out       output      o_out_valid / i_out_ready  one result per item
//   cfg       input       i_cfg_valid / o_cfg_ready  register index and data
//
// one item at a time, none taken until the last is through: a visible column
// runs the 32-step radix-2 divider, a hidden column none; a tick one divide and
// a frame step if due; a place three 64-step divides, none if behind
// synchronous active-low reset restores register defaults and clears state
// the next item is taken while a result waits; a stalled output holds the
// sequencer in its last step until the word is taken
module raycast_sprite_column_projector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_delta_time,
    input  logic [15:0]        i_sprite_x,
    input  logic [15:0]        i_sprite_y,
    input  logic [15:0]        i_player_x,
    input  logic [15:0]        i_player_y,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_plane_x,
    input  logic signed [15:0] i_plane_y,
    input  logic [10:0]        i_column,
    input  logic [15:0]        i_wall_depth,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_visible,
    output logic signed [15:0] o_top_y,
    output logic signed [15:0] o_bottom_y,
    output logic [15:0]        o_tex_u,
    output logic [7:0]         o_frame,
    output logic               o_animation_over,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    rscp_pkg::t_op        op;
    rscp_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    rscp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_op       (op)
    );

    rscp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_delta_time     (i_delta_time),
        .i_sprite_x       (i_sprite_x),
        .i_sprite_y       (i_sprite_y),
        .i_player_x       (i_player_x),
        .i_player_y       (i_player_y),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_plane_x        (i_plane_x),
        .i_plane_y        (i_plane_y),
        .i_column         (i_column),
        .i_wall_depth     (i_wall_depth),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_visible        (o_visible),
        .o_top_y          (o_top_y),
        .o_bottom_y       (o_bottom_y),
        .o_tex_u          (o_tex_u),
        .o_frame          (o_frame),
        .o_animation_over (o_animation_over)
    );
endmodule

/* rtl/core/rscp_div.sv */
// rscp_div: restoring divider, one quotient bit per cycle, 64 or 32 steps.
// Depends on nothing.
module rscp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_short,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quotient,
    output logic [63:0] o_remainder
);
    localparam logic [6:0] STEPS_LONG  = 7'd64;
    localparam logic [6:0] STEPS_SHORT = 7'd32;

    logic [63:0] r_rem, r_quo, r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] trial, diff;
    logic        ge;

    assign trial = {r_rem, r_quo[63]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_short ? STEPS_SHORT : STEPS_LONG;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_short ? {i_dividend[31:0], 32'd0} : i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[63:0] : trial[63:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

/* rtl/core/rscp_dp.sv */
// rscp_dp: datapath with config registers, shared multiplier, divider,
// geometry and timer state and the output register. Uses rscp_pkg, rscp_div.
module rscp_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rscp_pkg::t_op         i_op,
    output rscp_pkg::t_dp_status  o_status,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    input  logic [1:0]            i_cmd,
    input  logic [15:0]           i_delta_time,
    input  logic [15:0]           i_sprite_x,
    input  logic [15:0]           i_sprite_y,
    input  logic [15:0]           i_player_x,
    input  logic [15:0]           i_player_y,
    input  logic signed [15:0]    i_dir_x,
    input  logic signed [15:0]    i_dir_y,
    input  logic signed [15:0]    i_plane_x,
    input  logic signed [15:0]    i_plane_y,
    input  logic [10:0]           i_column,
    input  logic [15:0]           i_wall_depth,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_visible,
    output logic signed [15:0]    o_top_y,
    output logic signed [15:0]    o_bottom_y,
    output logic [15:0]           o_tex_u,
    output logic [7:0]            o_frame,
    output logic                  o_animation_over
);
    localparam logic signed [17:0] POS_HALF = 18'(1 << (rscp_pkg::POS_FRAC_BITS - 1));

    // config
    logic [11:0] r_vw, r_vh;
    logic [10:0] r_fw, r_fh;
    logic [7:0]  r_row;
    logic [8:0]  r_fc;
    logic [23:0] r_fd;

    // input word
    logic [1:0]         r_cmd;
    logic [15:0]        r_dt, r_sx, r_sy, r_px, r_py, r_wd;
    logic signed [15:0] r_dx, r_dy, r_plx, r_ply;
    logic [10:0]        r_col;

    // work registers
    logic signed [55:0] r_prod;
    logic signed [33:0] r_det;
    logic signed [35:0] r_tx, r_ty;
    logic [33:0]        r_n;
    logic signed [31:0] r_v;
    logic               r_vis, r_over;
    logic [15:0]        r_tex;

    // state
    logic [31:0]        r_elapsed, r_depth;
    logic [8:0]         r_fi;
    logic signed [16:0] r_cx;
    logic [15:0]        r_size;
    logic [11:0]        r_start, r_end;
    logic signed [15:0] r_top, r_bot;
    logic               r_in_front;

    // output word
    logic               r_out_valid, r_o_vis, r_o_over;
    logic signed [15:0] r_o_top, r_o_bot;
    logic [15:0]        r_o_tex;
    logic [7:0]         r_o_frame;

    // multiplier
    logic signed [37:0] m_a;
    logic signed [17:0] m_b;
    logic signed [55:0] m_p;
    logic signed [17:0] ox, oy;
    logic signed [36:0] txy;

    // divider
    logic        d_start, d_short, d_busy, d_done;
    logic [63:0] d_dividend, d_divisor, d_q, d_r;
    logic [55:0] prod_mag;

    assign ox  = $signed({2'b00, r_sx}) - $signed({2'b00, r_px}) + POS_HALF;
    assign oy  = $signed({2'b00, r_sy}) - $signed({2'b00, r_py}) + POS_HALF;
    assign txy = 37'(r_ty) + 37'(r_tx);

    // column terms
    logic signed [17:0] cx2;
    logic signed [19:0] off2;
    logic               vis_c;
    assign cx2  = {r_cx, 1'b0};
    assign off2 = $signed({8'd0, r_col, 1'b0}) - 20'(cx2) + $signed({4'd0, r_size});
    assign vis_c = r_in_front && ({1'b0, r_col} >= r_start) && ({1'b0, r_col} < r_end) &&
                   (r_col != 11'd0) && ({1'b0, r_col} < r_vw) &&
                   (r_depth < {16'd0, r_wd}) && (r_size != 16'd0);

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_op)
            rscp_pkg::OP_DET_A: begin m_a = 38'(r_plx); m_b = 18'(r_dy); end
            rscp_pkg::OP_DET_B: begin m_a = 38'(r_dx);  m_b = 18'(r_ply); end
            rscp_pkg::OP_TX_A:  begin m_a = 38'(r_dy);  m_b = ox; end
            rscp_pkg::OP_TX_B:  begin m_a = 38'(r_dx);  m_b = oy; end
            rscp_pkg::OP_TY_A:  begin m_a = 38'(r_plx); m_b = oy; end
            rscp_pkg::OP_TY_B:  begin m_a = 38'(r_ply); m_b = ox; end
            rscp_pkg::OP_CX_MUL: begin m_a = 38'(txy); m_b = $signed({6'd0, r_vw}); end
            rscp_pkg::OP_SZ_MUL: begin
                m_a = $signed({4'd0, r_det});
                m_b = $signed({6'd0, r_vh});
            end
            rscp_pkg::OP_COL_MUL: begin m_a = 38'(off2); m_b = $signed({7'd0, r_fw}); end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end
    assign m_p = m_a * m_b;

    // tick terms
    logic [32:0] tk_sum;
    logic [23:0] tk_dur;
    logic        fi_ge;
    logic [34:0] fr_total, fr_nm1;
    assign tk_sum   = {1'b0, r_elapsed} + {17'd0, r_dt};
    assign tk_dur   = (r_fd == 24'd0) ? 24'd1 : r_fd;
    assign fi_ge    = r_fi >= r_fc;
    assign fr_total = {26'd0, r_fi} + {1'b0, r_n};
    assign fr_nm1   = {1'b0, r_n} - 35'd1;

    assign prod_mag = r_prod[55] ? 56'(-r_prod) : 56'(r_prod);

    always_comb begin
        d_start    = 1'b0;
        d_short    = 1'b0;
        d_dividend = '0;
        d_divisor  = '0;
        case (i_op)
            rscp_pkg::OP_CX_DIV: begin
                d_start    = 1'b1;
                d_dividend = {8'd0, prod_mag};
                d_divisor  = {27'd0, r_ty, 1'b0};
            end
            rscp_pkg::OP_SZ_DIV: begin
                d_start    = 1'b1;
                d_dividend = {8'd0, prod_mag} << rscp_pkg::POS_FRAC_BITS;
                d_divisor  = {28'd0, r_ty} << rscp_pkg::VEC_FRAC_BITS;
            end
            rscp_pkg::OP_DP_DIV: begin
                d_start    = 1'b1;
                d_dividend = {28'd0, r_ty} << rscp_pkg::VEC_FRAC_BITS;
                d_divisor  = {30'd0, r_det};
            end
            rscp_pkg::OP_TK_DIV: begin
                d_start    = 1'b1;
                d_dividend = {31'd0, tk_sum};
                d_divisor  = {40'd0, tk_dur};
            end
            rscp_pkg::OP_FR_DIV: begin
                d_start    = 1'b1;
                d_dividend = {29'd0, fi_ge ? fr_nm1 : fr_total};
                d_divisor  = {55'd0, r_fc};
            end
            rscp_pkg::OP_COL_DIV: begin
                d_start    = 1'b1;
                d_short    = 1'b1;
                d_dividend = {32'd0, prod_mag[31:0]};
                d_divisor  = {47'd0, r_size, 1'b0};
            end
            default: d_start = 1'b0;
        endcase
    end

    rscp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (d_start),
        .i_short     (d_short),
        .i_dividend  (d_dividend),
        .i_divisor   (d_divisor),
        .o_busy      (d_busy),
        .o_done      (d_done),
        .o_quotient  (d_q),
        .o_remainder (d_r)
    );

    // center column from the floor division
    logic [63:0]        cx_m;
    logic signed [16:0] cx_val;
    always_comb begin
        cx_m = d_q + {63'd0, d_r != 64'd0};
        if (!r_prod[55]) begin
            cx_val = (d_q > 64'd65535) ? 17'sd65535 : $signed({1'b0, d_q[15:0]});
        end else begin
            cx_val = (cx_m > 64'd65536) ? -17'sd65536 : 17'(17'd0 - cx_m[16:0]);
        end
    end

    // extents and stripe
    logic signed [17:0] g_hdiff;
    logic signed [16:0] g_thalf;
    logic [16:0]        g_hsum;
    logic signed [19:0] g_e1, g_e2, g_e2p;
    logic signed [18:0] g_eh;
    logic signed [15:0] g_top, g_bot;
    logic [11:0]        g_start, g_end;
    always_comb begin
        g_hdiff = $signed({6'd0, r_vh}) - $signed({2'd0, r_size});
        g_thalf = g_hdiff[17:1];
        g_top   = (g_thalf < -17'sd32768) ? -16'sd32768 : g_thalf[15:0];
        g_hsum  = {5'd0, r_vh} + {1'b0, r_size};
        g_bot   = (g_hsum[16:1] > 16'd32767) ? 16'sd32767 : $signed(g_hsum[16:1]);
        g_e1    = 20'(cx2) - $signed({4'd0, r_size});
        if (g_e1[19]) begin
            g_start = 12'd0;
        end else begin
            g_start = (g_e1[19:1] > 19'd4095) ? 12'd4095 : g_e1[12:1];
        end
        g_e2  = 20'(cx2) + $signed({4'd0, r_size});
        g_e2p = g_e2 + 20'sd1;
        g_eh  = g_e2p[19:1];
        if (g_e2 >= $signed({7'd0, r_vw, 1'b0})) begin
            g_end = (r_vw == 12'd0) ? 12'd0 : r_vw - 12'd1;
        end else if (g_eh[18]) begin
            g_end = 12'd0;
        end else begin
            g_end = (g_eh > 19'sd4095) ? 12'd4095 : g_eh[11:0];
        end
    end

    // texture u
    logic [19:0]        fifw;
    logic signed [32:0] tex_sum;
    logic [15:0]        tex_val;
    assign fifw    = 20'(r_fi) * 20'(r_fw);
    assign tex_sum = 33'(r_v) + $signed({13'd0, fifw});
    always_comb begin
        if (tex_sum[32]) begin
            tex_val = 16'd0;
        end else if (tex_sum > 33'sd65535) begin
            tex_val = 16'hFFFF;
        end else begin
            tex_val = tex_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw  <= 12'd640;
            r_vh  <= 12'd480;
            r_fw  <= 11'd64;
            r_fh  <= 11'd64;
            r_row <= 8'd0;
            r_fc  <= 9'd1;
            r_fd  <= 24'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rscp_pkg::REG_VIEW_WIDTH:     r_vw  <= i_cfg_data[11:0];
                rscp_pkg::REG_VIEW_HEIGHT:    r_vh  <= i_cfg_data[11:0];
                rscp_pkg::REG_FRAME_WIDTH:    r_fw  <= i_cfg_data[10:0];
                rscp_pkg::REG_FRAME_HEIGHT:   r_fh  <= i_cfg_data[10:0];
                rscp_pkg::REG_SHEET_ROW:      r_row <= i_cfg_data[7:0];
                rscp_pkg::REG_FRAME_COUNT:    r_fc  <= i_cfg_data[8:0];
                rscp_pkg::REG_FRAME_DURATION: r_fd  <= i_cfg_data;
                default: r_row <= r_row;
            endcase
        end
    end

    // input word and scratch, no reset
    always_ff @(posedge i_clk) begin
        case (i_op)
            rscp_pkg::OP_LOAD: begin
                r_cmd <= i_cmd;        r_dt  <= i_delta_time;
                r_sx  <= i_sprite_x;   r_sy  <= i_sprite_y;
                r_px  <= i_player_x;   r_py  <= i_player_y;
                r_dx  <= i_dir_x;      r_dy  <= i_dir_y;
                r_plx <= i_plane_x;    r_ply <= i_plane_y;
                r_col <= i_column;     r_wd  <= i_wall_depth;
                r_vis <= 1'b0;         r_tex <= 16'd0;
                r_over <= 1'b0;
            end
            rscp_pkg::OP_DET_A, rscp_pkg::OP_TX_A, rscp_pkg::OP_TY_A,
            rscp_pkg::OP_CX_MUL, rscp_pkg::OP_SZ_MUL: r_prod <= m_p;
            rscp_pkg::OP_DET_B: r_det <= r_prod[33:0] - m_p[33:0];
            rscp_pkg::OP_TX_B:  r_tx  <= r_prod[35:0] - m_p[35:0];
            rscp_pkg::OP_TY_B:  r_ty  <= r_prod[35:0] - m_p[35:0];
            rscp_pkg::OP_NORM: begin
                if (r_det[33]) begin
                    r_det <= -r_det;
                    r_tx  <= -r_tx;
                    r_ty  <= -r_ty;
                end
            end
            rscp_pkg::OP_TK_SET: r_n <= d_q[33:0];
            rscp_pkg::OP_FR_ZERO: r_over <= 1'b1;
            rscp_pkg::OP_FR_DIV: r_over <= fi_ge || (fr_total >= {26'd0, r_fc});
            rscp_pkg::OP_COL_MUL: begin
                r_prod <= m_p;
                r_vis  <= vis_c;
            end
            rscp_pkg::OP_COL_SET: r_v <= r_prod[55] ? 32'(-d_q[31:0]) : $signed(d_q[31:0]);
            rscp_pkg::OP_TEX: r_tex <= tex_val;
            default: r_cmd <= r_cmd;
        endcase
    end

    // geometry and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0; r_fi <= '0; r_depth <= '0; r_cx <= '0;
            r_size <= '0; r_start <= '0; r_end <= '0; r_top <= '0; r_bot <= '0;
            r_in_front <= 1'b0;
        end else begin
            case (i_op)
                rscp_pkg::OP_CLEAR: begin
                    r_depth <= '0; r_cx <= '0; r_size <= '0; r_start <= '0;
                    r_end <= '0; r_top <= '0; r_bot <= '0; r_in_front <= 1'b0;
                end
                rscp_pkg::OP_CX_SET: r_cx <= cx_val;
                rscp_pkg::OP_SZ_SET: r_size <= (d_q > 64'd65535) ? 16'hFFFF : d_q[15:0];
                rscp_pkg::OP_DP_SET:
                    r_depth <= (d_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : d_q[31:0];
                rscp_pkg::OP_GEOM: begin
                    r_top <= g_top; r_bot <= g_bot;
                    r_start <= g_start; r_end <= g_end;
                    r_in_front <= 1'b1;
                end
                rscp_pkg::OP_TK_SET: r_elapsed <= d_r[31:0];
                rscp_pkg::OP_FR_ZERO: r_fi <= '0;
                rscp_pkg::OP_FR_SET: r_fi <= d_r[8:0];
                default: r_fi <= r_fi;
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == rscp_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == rscp_pkg::OP_EMIT) begin
            r_o_vis   <= r_vis;
            r_o_top   <= r_top;
            r_o_bot   <= r_bot;
            r_o_tex   <= r_tex;
            r_o_frame <= r_fi[7:0];
            r_o_over  <= r_over;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_visible        = r_o_vis;
    assign o_top_y          = r_o_top;
    assign o_bottom_y       = r_o_bot;
    assign o_tex_u          = r_o_tex;
    assign o_frame          = r_o_frame;
    assign o_animation_over = r_o_over;

    assign o_status.div_done = d_done;
    assign o_status.geom_bad = (r_det == 34'sd0) || r_ty[35] || (r_ty == 36'sd0);
    assign o_status.col_vis  = r_vis;
    assign o_status.n_zero   = (r_n == 34'd0);
    assign o_status.cnt_zero = (r_fc == 9'd0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.cmd      = r_cmd;

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_start |-> !d_busy) else $error("divider restarted while busy");
    a_tex_only_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == rscp_pkg::OP_TEX) |-> r_vis) else $error("texture step on hidden column");
    a_frame_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == rscp_pkg::OP_FR_SET) |=> (r_fi < r_fc)) else $error("frame out of range");
endmodule

/* rtl/core/rscp_ctrl.sv */
// rscp_ctrl: sequencer that walks the datapath through tick, place and
// column items. Uses rscp_pkg.
module rscp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rscp_pkg::t_dp_status i_status,
    output rscp_pkg::t_op        o_op
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_DET_A, S_DET_B, S_TX_A, S_TX_B, S_TY_A, S_TY_B, S_NORM, S_CHK, S_CLEAR,
        S_CX_MUL, S_CX_DIV, S_CX_WAIT, S_SZ_MUL, S_SZ_DIV, S_SZ_WAIT,
        S_DP_DIV, S_DP_WAIT, S_GEOM,
        S_TK_DIV, S_TK_WAIT, S_TK_CHK, S_FR_ZERO, S_FR_DIV, S_FR_WAIT,
        S_COL_MUL, S_COL_CHK, S_COL_DIV, S_COL_WAIT, S_TEX, S_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:    if (i_in_valid) r_state <= S_DISP;
                S_DISP: begin
                    case (i_status.cmd)
                        rscp_pkg::CMD_TICK:   r_state <= S_TK_DIV;
                        rscp_pkg::CMD_PLACE:  r_state <= S_DET_A;
                        rscp_pkg::CMD_COLUMN: r_state <= S_COL_MUL;
                        default:              r_state <= S_EMIT;
                    endcase
                end
                S_DET_A:   r_state <= S_DET_B;
                S_DET_B:   r_state <= S_TX_A;
                S_TX_A:    r_state <= S_TX_B;
                S_TX_B:    r_state <= S_TY_A;
                S_TY_A:    r_state <= S_TY_B;
                S_TY_B:    r_state <= S_NORM;
                S_NORM:    r_state <= S_CHK;
                S_CHK:     r_state <= i_status.geom_bad ? S_CLEAR : S_CX_MUL;
                S_CLEAR:   r_state <= S_EMIT;
                S_CX_MUL:  r_state <= S_CX_DIV;
                S_CX_DIV:  r_state <= S_CX_WAIT;
                S_CX_WAIT: if (i_status.div_done) r_state <= S_SZ_MUL;
                S_SZ_MUL:  r_state <= S_SZ_DIV;
                S_SZ_DIV:  r_state <= S_SZ_WAIT;
                S_SZ_WAIT: if (i_status.div_done) r_state <= S_DP_DIV;
                S_DP_DIV:  r_state <= S_DP_WAIT;
                S_DP_WAIT: if (i_status.div_done) r_state <= S_GEOM;
                S_GEOM:    r_state <= S_EMIT;
                S_TK_DIV:  r_state <= S_TK_WAIT;
                S_TK_WAIT: if (i_status.div_done) r_state <= S_TK_CHK;
                S_TK_CHK: begin
                    if (i_status.n_zero) begin
                        r_state <= S_EMIT;
                    end else if (i_status.cnt_zero) begin
                        r_state <= S_FR_ZERO;
                    end else begin
                        r_state <= S_FR_DIV;
                    end
                end
                S_FR_ZERO: r_state <= S_EMIT;
                S_FR_DIV:  r_state <= S_FR_WAIT;
                S_FR_WAIT: if (i_status.div_done) r_state <= S_EMIT;
                S_COL_MUL: r_state <= S_COL_CHK;
                S_COL_CHK: r_state <= i_status.col_vis ? S_COL_DIV : S_EMIT;
                S_COL_DIV: r_state <= S_COL_WAIT;
                S_COL_WAIT: if (i_status.div_done) r_state <= S_TEX;
                S_TEX:     r_state <= S_EMIT;
                S_EMIT:    if (i_status.out_free) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:     o_op = i_in_valid ? rscp_pkg::OP_LOAD : rscp_pkg::OP_IDLE;
            S_DET_A:    o_op = rscp_pkg::OP_DET_A;
            S_DET_B:    o_op = rscp_pkg::OP_DET_B;
            S_TX_A:     o_op = rscp_pkg::OP_TX_A;
            S_TX_B:     o_op = rscp_pkg::OP_TX_B;
            S_TY_A:     o_op = rscp_pkg::OP_TY_A;
            S_TY_B:     o_op = rscp_pkg::OP_TY_B;
            S_NORM:     o_op = rscp_pkg::OP_NORM;
            S_CLEAR:    o_op = rscp_pkg::OP_CLEAR;
            S_CX_MUL:   o_op = rscp_pkg::OP_CX_MUL;
            S_CX_DIV:   o_op = rscp_pkg::OP_CX_DIV;
            S_CX_WAIT:  o_op = i_status.div_done ? rscp_pkg::OP_CX_SET : rscp_pkg::OP_IDLE;
            S_SZ_MUL:   o_op = rscp_pkg::OP_SZ_MUL;
            S_SZ_DIV:   o_op = rscp_pkg::OP_SZ_DIV;
            S_SZ_WAIT:  o_op = i_status.div_done ? rscp_pkg::OP_SZ_SET : rscp_pkg::OP_IDLE;
            S_DP_DIV:   o_op = rscp_pkg::OP_DP_DIV;
            S_DP_WAIT:  o_op = i_status.div_done ? rscp_pkg::OP_DP_SET : rscp_pkg::OP_IDLE;
            S_GEOM:     o_op = rscp_pkg::OP_GEOM;
            S_TK_DIV:   o_op = rscp_pkg::OP_TK_DIV;
            S_TK_WAIT:  o_op = i_status.div_done ? rscp_pkg::OP_TK_SET : rscp_pkg::OP_IDLE;
            S_FR_ZERO:  o_op = rscp_pkg::OP_FR_ZERO;
            S_FR_DIV:   o_op = rscp_pkg::OP_FR_DIV;
            S_FR_WAIT:  o_op = i_status.div_done ? rscp_pkg::OP_FR_SET : rscp_pkg::OP_IDLE;
            S_COL_MUL:  o_op = rscp_pkg::OP_COL_MUL;
            S_COL_DIV:  o_op = rscp_pkg::OP_COL_DIV;
            S_COL_WAIT: o_op = i_status.div_done ? rscp_pkg::OP_COL_SET : rscp_pkg::OP_IDLE;
            S_TEX:      o_op = rscp_pkg::OP_TEX;
            S_EMIT:     o_op = i_status.out_free ? rscp_pkg::OP_EMIT : rscp_pkg::OP_IDLE;
            default:    o_op = rscp_pkg::OP_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_CX_WAIT || r_state == S_SZ_WAIT ||
        r_state == S_DP_WAIT || r_state == S_TK_WAIT || r_state == S_FR_WAIT ||
        r_state == S_COL_WAIT)) else $error("divider result outside a wait state");
    a_accept_goes_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISP)) else $error("accept lost");
endmodule
